// ===== hdl/cpfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clamp pusher feed sequencer package
// Shared types, codes and the microcode store of the feed sequencer.
// ----------------------------------------------------------------------------
package cpfs_pkg;

  localparam int unsigned POS_W   = 17;
  localparam int unsigned REM_W   = 24;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned UPC_W   = 5;

  localparam logic [POS_W-1:0] POS_FULL = 17'h10000;
  localparam logic [POS_W-1:0] POS_HALF = 17'h08000;
  localparam logic [POS_W-1:0] POS_ZERO = 17'h00000;

  localparam logic signed [REM_W-1:0] ONE_MM_Q8 = 24'sd256;
  localparam logic signed [REM_W-1:0] REM_MAX   = 24'sh7FFFFF;
  localparam logic signed [REM_W-1:0] REM_MIN   = 24'sh800000;

  localparam logic [CFG_W-1:0] CLAMP_DELAY_RST = 16'd1000;
  localparam logic [CFG_W-1:0] MOVE_DELAY_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] STROKE_RST      = 16'd6144;

  // Configuration register indexes.
  localparam logic [1:0] REG_CLAMP_DELAY = 2'd0;
  localparam logic [1:0] REG_MOVE_DELAY  = 2'd1;
  localparam logic [1:0] REG_STROKE      = 2'd2;

  // Command codes.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_EXTRUDE = 2'd1;
  localparam logic [1:0] CMD_HOME    = 2'd2;

  // Detector codes; anything else is an error.
  localparam logic [1:0] DET_UNDETECTED = 2'd0;
  localparam logic [1:0] DET_DETECTED   = 2'd1;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_LOCK_START   = 3'd1,
    PH_MOVE_START   = 3'd2,
    PH_LOCK_EXTRUDE = 3'd3,
    PH_PUSH         = 3'd4,
    PH_RELEASE      = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_OUT,
    OP_DEC_WAIT,
    OP_LOCK_START,
    OP_MOVE_START,
    OP_LOCK_EXTRUDE,
    OP_RELEASE,
    OP_SET_IDLE,
    OP_EXTRUDE,
    OP_HOME,
    OP_DIV_START,
    OP_PUSH_APPLY,
    OP_PHASE_LS,
    OP_PUSH_END
  } dp_op_t;

  typedef enum logic [4:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_ITEM,
    CND_IS_EXT,
    CND_IS_HOME,
    CND_NOT_TICK,
    CND_PH_IDLE,
    CND_WAIT_NZ,
    CND_PH_LS,
    CND_PH_MS,
    CND_PH_LE,
    CND_PH_PUSH,
    CND_PH_REL,
    CND_STOP,
    CND_DIV_BUSY,
    CND_REM_SMALL,
    CND_OUT_BUSY
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cnd;
    upc_t   target;
  } uword_t;

  // Status from the datapath that the jump conditions test.
  typedef struct packed {
    logic   cmd_ext;
    logic   cmd_home;
    logic   cmd_tick;
    phase_t phase;
    logic   wait_nz;
    logic   stop;
    logic   rem_small;
  } cpfs_flags_t;

  typedef struct packed {
    logic [POS_W-1:0]        fixed_target;
    logic [POS_W-1:0]        moving_target;
    logic [POS_W-1:0]        pusher_target;
    logic                    fixed_enabled;
    logic                    moving_enabled;
    logic                    pusher_enabled;
    phase_t                  phase;
    logic signed [REM_W-1:0] remaining;
  } cpfs_result_t;

  // Microcode addresses.
  localparam upc_t A_FIN      = 5'd0;
  localparam upc_t A_IDLE     = 5'd1;
  localparam upc_t A_DISPATCH = 5'd2;
  localparam upc_t A_DEC      = 5'd13;
  localparam upc_t A_LS       = 5'd14;
  localparam upc_t A_MS       = 5'd15;
  localparam upc_t A_LE       = 5'd16;
  localparam upc_t A_REL      = 5'd17;
  localparam upc_t A_EXT      = 5'd18;
  localparam upc_t A_HOME     = 5'd19;
  localparam upc_t A_PUSH     = 5'd20;
  localparam upc_t A_DIV_WAIT = 5'd22;
  localparam upc_t A_PEND     = 5'd26;

  function automatic uword_t uw(input dp_op_t op, input cond_t cnd, input upc_t target);
    uword_t w;
    w.op     = op;
    w.cnd    = cnd;
    w.target = target;
    return w;
  endfunction

  // The program. A word runs its operation, then jumps to its target when its
  // condition holds and steps to the next address otherwise.
  function automatic uword_t cpfs_ucode(input upc_t addr);
    uword_t w;
    unique case (addr)
      5'd0:    w = uw(OP_LOAD_OUT,     CND_OUT_BUSY,  A_FIN);
      5'd1:    w = uw(OP_NOP,          CND_NO_ITEM,   A_IDLE);
      5'd2:    w = uw(OP_NOP,          CND_IS_EXT,    A_EXT);
      5'd3:    w = uw(OP_NOP,          CND_IS_HOME,   A_HOME);
      5'd4:    w = uw(OP_NOP,          CND_NOT_TICK,  A_FIN);
      5'd5:    w = uw(OP_NOP,          CND_PH_IDLE,   A_FIN);
      5'd6:    w = uw(OP_NOP,          CND_WAIT_NZ,   A_DEC);
      5'd7:    w = uw(OP_NOP,          CND_PH_LS,     A_LS);
      5'd8:    w = uw(OP_NOP,          CND_PH_MS,     A_MS);
      5'd9:    w = uw(OP_NOP,          CND_PH_LE,     A_LE);
      5'd10:   w = uw(OP_NOP,          CND_PH_PUSH,   A_PUSH);
      5'd11:   w = uw(OP_NOP,          CND_PH_REL,    A_REL);
      5'd12:   w = uw(OP_SET_IDLE,     CND_ALWAYS,    A_FIN);
      5'd13:   w = uw(OP_DEC_WAIT,     CND_ALWAYS,    A_FIN);
      5'd14:   w = uw(OP_LOCK_START,   CND_ALWAYS,    A_FIN);
      5'd15:   w = uw(OP_MOVE_START,   CND_ALWAYS,    A_FIN);
      5'd16:   w = uw(OP_LOCK_EXTRUDE, CND_ALWAYS,    A_FIN);
      5'd17:   w = uw(OP_RELEASE,      CND_ALWAYS,    A_FIN);
      5'd18:   w = uw(OP_EXTRUDE,      CND_ALWAYS,    A_FIN);
      5'd19:   w = uw(OP_HOME,         CND_ALWAYS,    A_FIN);
      5'd20:   w = uw(OP_NOP,          CND_STOP,      A_PEND);
      5'd21:   w = uw(OP_DIV_START,    CND_NEVER,     A_FIN);
      5'd22:   w = uw(OP_NOP,          CND_DIV_BUSY,  A_DIV_WAIT);
      5'd23:   w = uw(OP_PUSH_APPLY,   CND_NEVER,     A_FIN);
      5'd24:   w = uw(OP_NOP,          CND_REM_SMALL, A_PEND);
      5'd25:   w = uw(OP_PHASE_LS,     CND_ALWAYS,    A_FIN);
      5'd26:   w = uw(OP_PUSH_END,     CND_ALWAYS,    A_FIN);
      default: w = uw(OP_NOP,          CND_ALWAYS,    A_IDLE);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cpfs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stroke fraction divider
// Computes min(round(mag * 65536 / stroke), 65536) one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cpfs_divider
  import cpfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [REM_W-1:0]       mag,
  input  logic [CFG_W-1:0]       stroke,
  output logic                   busy,
  output logic [POS_W-1:0]       quotient
);

  logic             busy_r, busy_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0] dvd_r, dvd_nxt;
  logic [POS_W-1:0] quo_r, quo_nxt;
  logic [31:0]      dividend;
  logic [POS_W-1:0] trial;
  logic             fits;

  // With mag below stroke the dividend stays under 2^32 and the quotient
  // needs only 17 bits; the upper 15 dividend bits seed the remainder.
  assign dividend = {mag[CFG_W-1:0], 16'h0000} + {17'd0, stroke[CFG_W-1:1]};
  assign trial    = {rem_r, dvd_r[POS_W-1]};
  assign fits     = trial >= {1'b0, stroke};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (start) begin
      if (mag >= {8'd0, stroke}) begin
        quo_nxt  = POS_FULL;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = {1'b0, dividend[31:17]};
        dvd_nxt  = dividend[16:0];
        quo_nxt  = POS_ZERO;
        cnt_nxt  = 5'd16;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? CFG_W'(trial - {1'b0, stroke}) : trial[CFG_W-1:0];
      dvd_nxt = {dvd_r[POS_W-2:0], 1'b0};
      quo_nxt = {quo_r[POS_W-2:0], fits};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hdl/cpfs_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the program store with conditional jumps.
// ----------------------------------------------------------------------------
module cpfs_sequencer
  import cpfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cpfs_flags_t flags,
  input  logic        in_valid,
  input  logic        div_busy,
  input  logic        out_busy,
  output dp_op_t      op,
  output logic        at_idle
);

  upc_t   pc_r, pc_nxt;
  uword_t word;
  logic   taken;

  assign word = cpfs_ucode(pc_r);

  always_comb begin
    unique case (word.cnd)
      CND_NEVER:     taken = 1'b0;
      CND_ALWAYS:    taken = 1'b1;
      CND_NO_ITEM:   taken = !in_valid;
      CND_IS_EXT:    taken = flags.cmd_ext;
      CND_IS_HOME:   taken = flags.cmd_home;
      CND_NOT_TICK:  taken = !flags.cmd_tick;
      CND_PH_IDLE:   taken = flags.phase == PH_IDLE;
      CND_WAIT_NZ:   taken = flags.wait_nz;
      CND_PH_LS:     taken = flags.phase == PH_LOCK_START;
      CND_PH_MS:     taken = flags.phase == PH_MOVE_START;
      CND_PH_LE:     taken = flags.phase == PH_LOCK_EXTRUDE;
      CND_PH_PUSH:   taken = flags.phase == PH_PUSH;
      CND_PH_REL:    taken = flags.phase == PH_RELEASE;
      CND_STOP:      taken = flags.stop;
      CND_DIV_BUSY:  taken = div_busy;
      CND_REM_SMALL: taken = flags.rem_small;
      CND_OUT_BUSY:  taken = out_busy;
      default:       taken = 1'b1;
    endcase
    pc_nxt = taken ? word.target : pc_r + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op      = word.op;
  assign at_idle = pc_r == A_IDLE;

endmodule
`default_nettype wire

// ===== hdl/cpfs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Feed sequencer datapath
// Configuration, latched beat fields, feed state and servo targets.
// ----------------------------------------------------------------------------
module cpfs_datapath
  import cpfs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_op_t                  op,
  input  logic                    in_accept,
  input  logic [1:0]              in_command,
  input  logic signed [REM_W-1:0] in_amount_q8,
  input  logic                    in_use_detector,
  input  logic                    in_require_filament,
  input  logic [1:0]              in_detector_status,
  input  logic                    in_home_fixed,
  input  logic                    in_home_moving,
  input  logic                    in_home_pusher,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic [POS_W-1:0]        div_quotient,
  output logic [REM_W-1:0]        div_mag,
  output logic [CFG_W-1:0]        div_stroke,
  output cpfs_flags_t             flags,
  output cpfs_result_t            result
);

  // Configuration.
  logic [CFG_W-1:0] clamp_delay_r, move_delay_r, stroke_r;

  // Fields of the beat being worked on.
  logic [1:0]              cmd_r;
  logic signed [REM_W-1:0] amt_r;
  logic                    use_det_r, req_fil_r, hf_r, hm_r, hp_r;
  logic [1:0]              det_r;

  // Feed state.
  phase_t                  phase_r, phase_nxt;
  logic [CFG_W-1:0]        wait_r, wait_nxt;
  logic signed [REM_W-1:0] rem_r, rem_nxt;
  logic                    gate_r, gate_nxt, need_r, need_nxt;
  logic [POS_W-1:0]        fix_r, fix_nxt, mov_r, mov_nxt, push_r, push_nxt;
  logic                    fix_en_r, fix_en_nxt, mov_en_r, mov_en_nxt;
  logic                    push_en_r, push_en_nxt;

  logic                    rem_pos;
  logic [REM_W-1:0]        mag;
  logic [CFG_W-1:0]        step_len;
  logic signed [REM_W:0]   sum;
  logic signed [REM_W-1:0] sum_sat;

  assign div_stroke = (stroke_r == '0) ? CFG_W'(1) : stroke_r;
  assign rem_pos    = !rem_r[REM_W-1] && (rem_r != '0);
  assign mag        = rem_r[REM_W-1] ? REM_W'(-rem_r) : rem_r;
  assign div_mag    = mag;
  assign step_len   = (mag >= {8'd0, div_stroke}) ? div_stroke : mag[CFG_W-1:0];

  always_comb begin
    sum = {amt_r[REM_W-1], amt_r} + {rem_r[REM_W-1], rem_r};
    if (!sum[REM_W] && sum[REM_W-1]) begin
      sum_sat = REM_MAX;
    end else if (sum[REM_W] && !sum[REM_W-1]) begin
      sum_sat = REM_MIN;
    end else begin
      sum_sat = sum[REM_W-1:0];
    end
  end

  always_comb begin
    flags.cmd_ext   = cmd_r == CMD_EXTRUDE;
    flags.cmd_home  = cmd_r == CMD_HOME;
    flags.cmd_tick  = cmd_r == CMD_TICK;
    flags.phase     = phase_r;
    flags.wait_nz   = wait_r != '0;
    flags.rem_small = (rem_r <= ONE_MM_Q8) && (rem_r >= -ONE_MM_Q8);
    if (!gate_r) begin
      flags.stop = 1'b0;
    end else if (det_r == DET_UNDETECTED) begin
      flags.stop = need_r;
    end else if (det_r == DET_DETECTED) begin
      flags.stop = !need_r;
    end else begin
      flags.stop = 1'b1;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    wait_nxt    = wait_r;
    rem_nxt     = rem_r;
    gate_nxt    = gate_r;
    need_nxt    = need_r;
    fix_nxt     = fix_r;
    mov_nxt     = mov_r;
    push_nxt    = push_r;
    fix_en_nxt  = fix_en_r;
    mov_en_nxt  = mov_en_r;
    push_en_nxt = push_en_r;
    unique case (op)
      OP_DEC_WAIT: begin
        wait_nxt = wait_r - CFG_W'(1);
      end
      OP_LOCK_START: begin
        fix_nxt    = POS_FULL;
        mov_nxt    = POS_ZERO;
        fix_en_nxt = 1'b1;
        mov_en_nxt = 1'b1;
        wait_nxt   = clamp_delay_r;
        phase_nxt  = PH_MOVE_START;
      end
      OP_MOVE_START: begin
        push_nxt    = rem_pos ? POS_ZERO : POS_FULL;
        push_en_nxt = 1'b1;
        wait_nxt    = move_delay_r;
        phase_nxt   = PH_LOCK_EXTRUDE;
      end
      OP_LOCK_EXTRUDE: begin
        fix_nxt    = POS_ZERO;
        mov_nxt    = POS_FULL;
        fix_en_nxt = 1'b1;
        mov_en_nxt = 1'b1;
        wait_nxt   = clamp_delay_r;
        phase_nxt  = PH_PUSH;
      end
      OP_RELEASE: begin
        fix_en_nxt  = 1'b0;
        mov_en_nxt  = 1'b0;
        push_en_nxt = 1'b0;
        phase_nxt   = PH_IDLE;
      end
      OP_SET_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      OP_EXTRUDE: begin
        gate_nxt = use_det_r;
        need_nxt = req_fil_r;
        rem_nxt  = sum_sat;
        if (phase_r == PH_IDLE || phase_r == PH_RELEASE) begin
          phase_nxt = PH_LOCK_START;
          wait_nxt  = '0;
        end
      end
      OP_HOME: begin
        // Naming no axis homes every axis to zero.
        if (!hf_r && !hm_r && !hp_r) begin
          fix_nxt     = POS_ZERO;
          mov_nxt     = POS_ZERO;
          push_nxt    = POS_ZERO;
          fix_en_nxt  = 1'b1;
          mov_en_nxt  = 1'b1;
          push_en_nxt = 1'b1;
        end else begin
          if (hf_r) begin
            fix_nxt    = POS_ZERO;
            fix_en_nxt = 1'b1;
          end
          if (hm_r) begin
            mov_nxt    = POS_ZERO;
            mov_en_nxt = 1'b1;
          end
          if (hp_r) begin
            push_nxt    = POS_HALF;
            push_en_nxt = 1'b1;
          end
        end
      end
      OP_PUSH_APPLY: begin
        push_en_nxt = 1'b1;
        wait_nxt    = move_delay_r;
        if (rem_pos) begin
          push_nxt = div_quotient;
          rem_nxt  = rem_r - $signed({8'd0, step_len});
        end else begin
          push_nxt = POS_FULL - div_quotient;
          rem_nxt  = rem_r + $signed({8'd0, step_len});
        end
      end
      OP_PHASE_LS: begin
        phase_nxt = PH_LOCK_START;
      end
      OP_PUSH_END: begin
        rem_nxt    = '0;
        fix_nxt    = POS_ZERO;
        mov_nxt    = POS_FULL;
        fix_en_nxt = 1'b1;
        mov_en_nxt = 1'b1;
        wait_nxt   = clamp_delay_r;
        phase_nxt  = PH_RELEASE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_delay_r <= CLAMP_DELAY_RST;
      move_delay_r  <= MOVE_DELAY_RST;
      stroke_r      <= STROKE_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_CLAMP_DELAY) begin
        clamp_delay_r <= cfg_data;
      end
      if (cfg_index == REG_MOVE_DELAY) begin
        move_delay_r <= cfg_data;
      end
      if (cfg_index == REG_STROKE) begin
        stroke_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r     <= in_command;
      amt_r     <= in_amount_q8;
      use_det_r <= in_use_detector;
      req_fil_r <= in_require_filament;
      det_r     <= in_detector_status;
      hf_r      <= in_home_fixed;
      hm_r      <= in_home_moving;
      hp_r      <= in_home_pusher;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wait_r    <= '0;
      rem_r     <= '0;
      gate_r    <= 1'b0;
      need_r    <= 1'b0;
      fix_r     <= POS_ZERO;
      mov_r     <= POS_ZERO;
      push_r    <= POS_ZERO;
      fix_en_r  <= 1'b0;
      mov_en_r  <= 1'b0;
      push_en_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      wait_r    <= wait_nxt;
      rem_r     <= rem_nxt;
      gate_r    <= gate_nxt;
      need_r    <= need_nxt;
      fix_r     <= fix_nxt;
      mov_r     <= mov_nxt;
      push_r    <= push_nxt;
      fix_en_r  <= fix_en_nxt;
      mov_en_r  <= mov_en_nxt;
      push_en_r <= push_en_nxt;
    end
  end

  always_comb begin
    result.fixed_target   = fix_r;
    result.moving_target  = mov_r;
    result.pusher_target  = push_r;
    result.fixed_enabled  = fix_en_r;
    result.moving_enabled = mov_en_r;
    result.pusher_enabled = push_en_r;
    result.phase          = phase_r;
    result.remaining      = rem_r;
  end

endmodule
`default_nettype wire

// ===== hdl/clamp_pusher_feed_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clamp pusher feed sequencer
// Inchworm filament feeder: drives two clamps and a pusher from tick, extrude
// and home beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_*) carry a tick, extrude or home command. Each accepted
//   beat yields exactly one output beat (out_*) with the servo targets,
//   enables, phase and remaining amount after that beat.
//   A beat is taken one at a time by a microcoded sequencer. The result is
//   registered after a run of steps set by the command and the phase; a tick
//   that runs the push step also waits for the stroke divider, which produces
//   one quotient bit per cycle, or skips the bit loop and gives full travel
//   when the remaining amount covers a full stroke.
//   The next beat is accepted the cycle after the result is registered, even
//   while that result waits for the receiver.
//   If the receiver stalls, the result register holds its beat and the
//   sequencer waits at its final step until the register frees up.
//   Configuration writes (cfg_*) take effect at once and are meant for times
//   when no beat is in flight.
//   Reset clears all feed state, restores the register defaults and leaves
//   the sequencer ready for a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
module clamp_pusher_feed_sequencer
  import cpfs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic signed [REM_W-1:0] in_amount_q8,
  input  logic                    in_use_detector,
  input  logic                    in_require_filament,
  input  logic [1:0]              in_detector_status,
  input  logic                    in_home_fixed,
  input  logic                    in_home_moving,
  input  logic                    in_home_pusher,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [POS_W-1:0]        out_fixed_target,
  output logic [POS_W-1:0]        out_moving_target,
  output logic [POS_W-1:0]        out_pusher_target,
  output logic                    out_fixed_enabled,
  output logic                    out_moving_enabled,
  output logic                    out_pusher_enabled,
  output logic                    out_busy_res,
  output logic [2:0]              out_phase_now,
  output logic signed [REM_W-1:0] out_remaining_q8,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  dp_op_t           op;
  logic             at_idle;
  logic             in_accept;
  logic             out_busy;
  logic             load;
  cpfs_flags_t      flags;
  cpfs_result_t     result;
  logic [REM_W-1:0] div_mag;
  logic [CFG_W-1:0] div_stroke;
  logic             div_busy;
  logic [POS_W-1:0] div_quotient;

  logic             out_valid_r, out_valid_nxt;
  cpfs_result_t     out_r;

  assign in_stall  = !at_idle;
  assign in_accept = in_valid && !in_stall;
  assign out_busy  = out_valid_r && out_stall;
  assign load      = (op == OP_LOAD_OUT) && !out_busy;

  cpfs_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .flags    (flags),
    .in_valid (in_valid),
    .div_busy (div_busy),
    .out_busy (out_busy),
    .op       (op),
    .at_idle  (at_idle)
  );

  cpfs_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .in_accept           (in_accept),
    .in_command          (in_command),
    .in_amount_q8        (in_amount_q8),
    .in_use_detector     (in_use_detector),
    .in_require_filament (in_require_filament),
    .in_detector_status  (in_detector_status),
    .in_home_fixed       (in_home_fixed),
    .in_home_moving      (in_home_moving),
    .in_home_pusher      (in_home_pusher),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .div_quotient        (div_quotient),
    .div_mag             (div_mag),
    .div_stroke          (div_stroke),
    .flags               (flags),
    .result              (result)
  );

  cpfs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == OP_DIV_START),
    .mag      (div_mag),
    .stroke   (div_stroke),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fixed_target   = out_r.fixed_target;
  assign out_moving_target  = out_r.moving_target;
  assign out_pusher_target  = out_r.pusher_target;
  assign out_fixed_enabled  = out_r.fixed_enabled;
  assign out_moving_enabled = out_r.moving_enabled;
  assign out_pusher_enabled = out_r.pusher_enabled;
  assign out_busy_res       = out_r.phase != PH_IDLE;
  assign out_phase_now      = out_r.phase;
  assign out_remaining_q8   = out_r.remaining;

endmodule
`default_nettype wire

// ===== hdl/cpfs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Feed sequencer port checker
// Watches the top level ports for ordering and value rules.
// ----------------------------------------------------------------------------
module cpfs_checker
  import cpfs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic [POS_W-1:0]        out_fixed_target,
  input  wire logic [POS_W-1:0]        out_moving_target,
  input  wire logic [POS_W-1:0]        out_pusher_target,
  input  wire logic                    out_busy_res,
  input  wire logic [2:0]              out_phase_now,
  input  wire logic signed [REM_W-1:0] out_remaining_q8
);

  // A beat is worked on alone: the input closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a beat is in work");

  // A result never shows up the cycle after its beat was accepted.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared without sequencer work");

  // The busy flag mirrors the phase.
  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_busy_res == (out_phase_now != PH_IDLE)))
    else $error("busy flag disagrees with phase");

  // Servo targets stay inside their travel.
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fixed_target <= POS_FULL) && (out_moving_target <= POS_FULL)
                  && (out_pusher_target <= POS_FULL))
    else $error("servo target beyond full travel");

  // A stalled result beat holds: it stays valid with its remaining amount.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_remaining_q8)))
    else $error("stalled result beat changed");

endmodule

bind clamp_pusher_feed_sequencer cpfs_checker u_checker (.*);
`default_nettype wire
